// ===== rtl/partition_tagged_name_cache_macros.svh =====
// Assertion macros for the partition tagged name cache checker.
// Include with the bare file name; no other dependencies.
`ifndef PARTITION_TAGGED_NAME_CACHE_MACROS_SVH
`define PARTITION_TAGGED_NAME_CACHE_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define PTNC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define PTNC_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/ptnc_pkg.sv =====
// Types, request codes and defaults for the partition tagged name cache.
// No dependencies; used by the top level, the entry RAM user and the checker.
package ptnc_pkg;

	localparam int ENTRIES_DEF = 64;

	localparam logic [1:0] REQ_INVALIDATE = 2'd0;
	localparam logic [1:0] REQ_LOOKUP     = 2'd1;
	localparam logic [1:0] REQ_ADD        = 2'd2;

	localparam logic [7:0] NO_PART = 8'hFF;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  part;
		logic [31:0] cluster;
		logic [63:0] name_high;
		logic [63:0] name_low;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [63:0] found_high;
		logic [63:0] found_low;
	} rsp_t;

	// One table slot as held in the entry RAM.
	typedef struct packed {
		logic [31:0] key;
		logic [63:0] name_high;
		logic [63:0] name_low;
	} entry_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

// ===== rtl/partition_tagged_name_cache.sv =====
// Partition tagged name cache: cluster number to 16-byte name, linear scan.
// Invalidate, add, unused codes, partition misses and empty-table lookups: strobe in the cycle after accept.
// Lookup: one slot read per cycle from the single entry RAM read port; the key in the
// registered read data is compared and the scan stops at the first hit or the last filled slot.
// busy is high only during a lookup scan; results cannot be held off.
// Reset clears the fill count and sets the tag to 255; RAM contents are not cleared.
module partition_tagged_name_cache #(
	parameter int ENTRIES = ptnc_pkg::ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ptnc_pkg::req_t req,
	output logic           done,
	output ptnc_pkg::rsp_t rsp
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	ptnc_pkg::state_t state_q, state_d;
	logic [CW-1:0]    count_q;
	logic [7:0]       part_q;
	logic [CW-1:0]    rd_idx_q;
	logic             cmp_vld_q;
	logic             cmp_last_q;
	logic             done_q;
	logic [31:0]      cluster_q;
	ptnc_pkg::rsp_t   rsp_q;

	logic             accept;
	logic             full;
	logic             new_part;
	logic [CW-1:0]    wr_slot;
	logic             wr_en;
	logic             rd_en;
	logic             key_match;
	logic             scan_done;
	logic             go_scan;
	logic             fin;
	logic             fin_hit;
	ptnc_pkg::entry_t wr_entry;
	ptnc_pkg::entry_t rd_entry;

	assign accept   = start && (state_q == ptnc_pkg::ST_IDLE);
	assign full     = (count_q == CW'(ENTRIES));
	assign new_part = (req.part != part_q);
	assign wr_slot  = new_part ? '0 : count_q;
	assign wr_en    = accept && (req.req_type == ptnc_pkg::REQ_ADD) && !full;

	assign wr_entry.key       = req.cluster;
	assign wr_entry.name_high = req.name_high;
	assign wr_entry.name_low  = req.name_low;

	assign rd_en     = (state_q == ptnc_pkg::ST_SCAN) && (rd_idx_q < count_q);
	assign key_match = (rd_entry.key == cluster_q);
	assign scan_done = (state_q == ptnc_pkg::ST_SCAN) && cmp_vld_q && (key_match || cmp_last_q);

	ptnc_ram #(
		.WIDTH($bits(ptnc_pkg::entry_t)),
		.DEPTH(ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_slot[AW-1:0]),
		.wdata(wr_entry),
		.re   (rd_en),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(rd_entry)
	);

	always_comb begin
		state_d = state_q;
		go_scan = 1'b0;
		fin     = 1'b0;
		fin_hit = 1'b0;
		case (state_q)
			ptnc_pkg::ST_IDLE: begin
				if (accept) begin
					if ((req.req_type == ptnc_pkg::REQ_LOOKUP) && !new_part &&
					    (count_q != '0)) begin
						go_scan = 1'b1;
						state_d = ptnc_pkg::ST_SCAN;
					end else begin
						fin = 1'b1;
					end
				end
			end
			ptnc_pkg::ST_SCAN: begin
				if (scan_done) begin
					fin     = 1'b1;
					fin_hit = key_match;
					state_d = ptnc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptnc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ptnc_pkg::ST_IDLE;
			count_q    <= '0;
			part_q     <= ptnc_pkg::NO_PART;
			rd_idx_q   <= '0;
			cmp_vld_q  <= 1'b0;
			cmp_last_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (accept) begin
				case (req.req_type)
					ptnc_pkg::REQ_INVALIDATE: begin
						count_q <= '0;
						part_q  <= ptnc_pkg::NO_PART;
					end
					ptnc_pkg::REQ_ADD: begin
						if (!full) begin
							count_q <= wr_slot + CW'(1);
							part_q  <= req.part;
						end
					end
					default: begin
					end
				endcase
			end
			if (go_scan) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			// Drop the compare pipe once the scan has answered
			cmp_vld_q  <= rd_en && !scan_done;
			cmp_last_q <= (rd_idx_q == count_q - CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (go_scan) begin
			cluster_q <= req.cluster;
		end
		if (fin) begin
			rsp_q.hit        <= fin_hit;
			rsp_q.found_high <= fin_hit ? rd_entry.name_high : 64'd0;
			rsp_q.found_low  <= fin_hit ? rd_entry.name_low : 64'd0;
		end
	end

	assign busy = (state_q != ptnc_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== rtl/ptnc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ptnc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ptnc_checker.sv =====
// Port level checker for the partition tagged name cache, bound to the top level.
// Depends on ptnc_pkg and partition_tagged_name_cache_macros.svh.
`include "partition_tagged_name_cache_macros.svh"

module ptnc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input ptnc_pkg::req_t req,
	input logic           done,
	input ptnc_pkg::rsp_t rsp
);

	`PTNC_ASSERT(a_miss_zero, clk, arst_n, (done && !rsp.hit) |-> ((rsp.found_high == 64'd0) && (rsp.found_low == 64'd0)), "miss result carries a non-zero name")
	`PTNC_ASSERT(a_quick_req, clk, arst_n, (start && !busy && (req.req_type != ptnc_pkg::REQ_LOOKUP)) |=> (done && !rsp.hit && !busy), "non-lookup request did not answer next cycle")
	`PTNC_ASSERT(a_scan_ends, clk, arst_n, $fell(busy) |-> done, "scan ended without a result")
	`PTNC_ASSERT(a_no_stray, clk, arst_n, done |-> ($past(busy) || $past(start && !busy)), "result without a request")
	// Reset is asynchronous and loads the reset values at once; the block must stay idle with no result strobe
	`PTNC_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |=> (!busy && !done), "block not idle in reset")

endmodule

bind partition_tagged_name_cache ptnc_checker u_ptnc_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.done  (done),
	.rsp   (rsp)
);
